// File: rtl/core/assert_macros.svh
// Assertion macros for the envelope RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define EAE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("envelope check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define EAE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("envelope sequence check failed");

`endif

// File: rtl/core/eae_pkg.sv
// Types, constants and the log table function of the envelope generator.
package eae_pkg;

  localparam int LEVEL_FRAC_BITS = 24;
  localparam int SAMPLE_BITS     = 16;
  localparam int LEVEL_W         = 25;
  localparam int LEN_W           = 24;
  localparam int CFG_W           = 25;
  localparam int FACTOR_W        = 32;
  localparam int LN_W            = 36;
  localparam int NUM_W           = 37;
  localparam int PROD_W          = 57;

  localparam logic [LEVEL_W-1:0]         LEVEL_ONE = 25'h1000000;
  localparam logic signed [FACTOR_W-1:0] Q30_ONE   = 32'sh40000000;
  localparam logic signed [LN_W-1:0]     LN2_Q30   = 36'sd744261118;

  // Register defaults after reset
  localparam logic [LEN_W-1:0] ATTACK_LEN_RST  = 24'd144000;
  localparam logic [LEN_W-1:0] DECAY_LEN_RST   = 24'd24000;
  localparam logic [LEN_W-1:0] RELEASE_LEN_RST = 24'd240000;
  localparam logic [CFG_W-1:0] SUSTAIN_RST     = 25'd16777216;
  localparam logic [CFG_W-1:0] FLOOR_RST       = 25'd16777;

  typedef enum logic [2:0] {
    CFG_ATTACK_LEN  = 3'd0,
    CFG_DECAY_LEN   = 3'd1,
    CFG_RELEASE_LEN = 3'd2,
    CFG_SUSTAIN     = 3'd3,
    CFG_FLOOR       = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_OFF     = 2'd1,
    REQ_ATTACK  = 2'd2,
    REQ_RELEASE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OFF     = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } stage_e;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_LNE_GO, SQ_LNE_WAIT, SQ_LNS_GO, SQ_LNS_WAIT, SQ_DIV_GO, SQ_DIV_WAIT,
    SQ_MLV_GO, SQ_MLV_WAIT, SQ_MSP_GO, SQ_MSP_WAIT, SQ_OUT
  } seq_e;

  typedef enum logic [2:0] {
    LG_IDLE, LG_NORM, LG_POS, LG_LOOK, LG_MUL
  } log_e;

  typedef enum logic [1:0] {
    DV_IDLE, DV_RUN, DV_FIX
  } div_e;

  typedef struct packed {
    logic [1:0]                   req_type;
    logic signed [SAMPLE_BITS-1:0] sample_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [2:0]                    stage_now;
    logic [LEVEL_W-1:0]            level_now;
  } out_t;

  // quotient of two nonnegative constants by shift and subtract
  function automatic longint ediv(input longint num, input longint den);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int i = 62; i >= 0; i--) begin
      r = (r <<< 1) | longint'(num[i]);
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + k/depth) in Q30 via 2*atanh(f/(2+f)); evaluated at elaboration only
  function automatic longint ln_entry(input int k, input int depth);
    longint den;
    longint y;
    longint y2;
    longint t;
    longint sum;
    den = 2 * longint'(depth) + longint'(k);
    y   = ediv(longint'(k) << 30, den);
    y2  = (y * y) >>> 30;
    t   = y;
    sum = y;
    for (int n = 3; n < 41; n += 2) begin
      t   = (t * y2) >>> 30;
      sum = sum + ediv(t, longint'(n));
    end
    return 2 * sum;
  endfunction

endpackage

// File: rtl/core/exponential_adsr_envelope_top.sv
// Exponential ADSR envelope generator, top level with sequencer and registers.
//
// One item at a time: in_ready_o is high only while the sequencer is idle. An audio
// sample in off or sustain gives its result after one 25-step serial multiply of
// sample by level; a sample in attack, decay or release first runs a 25-step level
// update multiply, then the sample multiply. An attack or release command evaluates
// two logarithms (each with a bit-serial normalize of the level) and a 37-step
// restoring divide and runs no multiply; a sample that chains into decay does the
// same, then both multiplies. An off command uses none of these units. The sequencer
// returns to idle at the edge that registers the result. Results go through an
// output register, so the next item is taken while a result waits. Configuration
// writes are always accepted and must only be made while the block is idle.
module exponential_adsr_envelope_top import eae_pkg::*; #(
  parameter int LOG_TABLE_DEPTH = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

`include "assert_macros.svh"

  localparam logic signed [PROD_W-1:0] HalfLevel = 57'sd8388608;
  localparam logic signed [PROD_W-1:0] HalfQ30   = 57'sd536870912;
  localparam logic signed [PROD_W-1:0] SmpMax    = 57'sd32767;
  localparam logic signed [PROD_W-1:0] SmpMin    = -57'sd32768;

  // configuration registers
  logic [LEN_W-1:0] atk_len_q, dec_len_q, rel_len_q;
  logic [CFG_W-1:0] sus_q, floor_q;

  // envelope state
  seq_e                       state_q, state_d;
  stage_e                     stage_q, stage_d;
  logic [LEVEL_W-1:0]         level_q, level_d;
  logic signed [FACTOR_W-1:0] factor_q, factor_d;
  logic [LEN_W-1:0]           count_q, count_d;
  logic [LEN_W-1:0]           end_q, end_d;
  logic                       out_valid_q, out_valid_d;
  out_t                       out_q, out_d;

  // per-item working registers
  logic                          is_cmd_q, is_cmd_d;
  logic [LEVEL_W-1:0]            fa_start_q, fa_start_d, fa_end_q, fa_end_d;
  logic signed [LN_W-1:0]        lnend_q, lnend_d, lnstart_q, lnstart_d;
  logic signed [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic signed [SAMPLE_BITS-1:0] res_q, res_d;

  // unit handshakes
  logic                       log_start, log_done;
  logic [LEVEL_W-1:0]         log_x;
  logic signed [LN_W-1:0]     log_ln;
  logic                       div_start, div_done;
  logic signed [FACTOR_W-1:0] div_factor;
  logic                       mul_start, mul_done;
  logic [LEVEL_W-1:0]         mul_a;
  logic signed [FACTOR_W-1:0] mul_b;
  logic signed [PROD_W-1:0]   mul_p;

  // derived levels and lengths
  logic [LEVEL_W-1:0] sus_c, floor_c, floor_eff, decay_target;
  logic [LEN_W-1:0]   atk_eff, dec_eff, rel_eff;
  logic               ramp;
  logic signed [PROD_W-1:0] lv_round, smp_round, smp_shift;

  assign sus_c        = (sus_q > LEVEL_ONE) ? LEVEL_ONE : sus_q;
  assign floor_c      = (floor_q > LEVEL_ONE) ? LEVEL_ONE : floor_q;
  assign floor_eff    = (floor_c == '0) ? LEVEL_W'(1) : floor_c;
  assign decay_target = (sus_c > floor_eff) ? sus_c : floor_eff;
  assign atk_eff      = (atk_len_q == '0) ? LEN_W'(1) : atk_len_q;
  assign dec_eff      = (dec_len_q == '0) ? LEN_W'(1) : dec_len_q;
  assign rel_eff      = (rel_len_q == '0) ? LEN_W'(1) : rel_len_q;
  assign ramp = (stage_q == ST_ATTACK) || (stage_q == ST_DECAY) || (stage_q == ST_RELEASE);

  assign lv_round  = (mul_p + HalfQ30) >>> 30;
  assign smp_round = mul_p + HalfLevel;
  assign smp_shift = smp_round >>> LEVEL_FRAC_BITS;

  assign log_x = (state_q == SQ_LNE_GO) ? fa_end_q : fa_start_q;
  assign mul_a = level_q;
  assign mul_b = (state_q == SQ_MSP_GO) ? FACTOR_W'(sample_q) : factor_q;

  // sequencer: decode, stage entry, factor, level update, sample scaling
  always_comb begin
    state_d     = state_q;
    stage_d     = stage_q;
    level_d     = level_q;
    factor_d    = factor_q;
    count_d     = count_q;
    end_d       = end_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    is_cmd_d    = is_cmd_q;
    fa_start_d  = fa_start_q;
    fa_end_d    = fa_end_q;
    lnend_d     = lnend_q;
    lnstart_d   = lnstart_q;
    sample_d    = sample_q;
    res_d       = res_q;
    log_start   = 1'b0;
    div_start   = 1'b0;
    mul_start   = 1'b0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      SQ_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          is_cmd_d = 1'b1;
          res_d    = '0;
          sample_d = in_data_i.sample_in;
          case (in_data_i.req_type)
            REQ_OFF: begin
              stage_d  = ST_OFF;
              level_d  = '0;
              factor_d = Q30_ONE;
              count_d  = '0;
              end_d    = '0;
              state_d  = SQ_OUT;
            end
            REQ_ATTACK: begin
              stage_d    = ST_ATTACK;
              count_d    = '0;
              end_d      = atk_eff;
              level_d    = floor_eff;
              fa_start_d = floor_eff;
              fa_end_d   = LEVEL_ONE;
              state_d    = SQ_LNE_GO;
            end
            REQ_RELEASE: begin
              stage_d    = ST_RELEASE;
              count_d    = '0;
              end_d      = rel_eff;
              fa_start_d = level_q;
              fa_end_d   = floor_eff;
              state_d    = SQ_LNE_GO;
            end
            default: begin
              is_cmd_d = 1'b0;
              if (!ramp) begin
                state_d = SQ_MSP_GO;
              end else if (count_q >= end_q) begin
                // stage length reached: chain to the next stage
                count_d = '0;
                case (stage_q)
                  ST_ATTACK: begin
                    stage_d    = ST_DECAY;
                    end_d      = dec_eff;
                    level_d    = LEVEL_ONE;
                    fa_start_d = LEVEL_ONE;
                    fa_end_d   = decay_target;
                    state_d    = SQ_LNE_GO;
                  end
                  ST_DECAY: begin
                    stage_d  = ST_SUSTAIN;
                    end_d    = '0;
                    level_d  = sus_c;
                    factor_d = Q30_ONE;
                    state_d  = SQ_MLV_GO;
                  end
                  default: begin
                    stage_d  = ST_OFF;
                    end_d    = '0;
                    level_d  = '0;
                    factor_d = Q30_ONE;
                    state_d  = SQ_MLV_GO;
                  end
                endcase
              end else begin
                state_d = SQ_MLV_GO;
              end
            end
          endcase
        end
      end
      SQ_LNE_GO: begin
        log_start = 1'b1;
        state_d   = SQ_LNE_WAIT;
      end
      SQ_LNE_WAIT: begin
        if (log_done) begin
          lnend_d = log_ln;
          state_d = SQ_LNS_GO;
        end
      end
      SQ_LNS_GO: begin
        log_start = 1'b1;
        state_d   = SQ_LNS_WAIT;
      end
      SQ_LNS_WAIT: begin
        if (log_done) begin
          lnstart_d = log_ln;
          state_d   = SQ_DIV_GO;
        end
      end
      SQ_DIV_GO: begin
        div_start = 1'b1;
        state_d   = SQ_DIV_WAIT;
      end
      SQ_DIV_WAIT: begin
        if (div_done) begin
          factor_d = div_factor;
          state_d  = is_cmd_q ? SQ_OUT : SQ_MLV_GO;
        end
      end
      SQ_MLV_GO: begin
        mul_start = 1'b1;
        state_d   = SQ_MLV_WAIT;
      end
      // level times factor, rounded half up and clamped to [0, 1.0]
      SQ_MLV_WAIT: begin
        if (mul_done) begin
          if (mul_p <= 0) begin
            level_d = '0;
          end else if (lv_round > PROD_W'(LEVEL_ONE)) begin
            level_d = LEVEL_ONE;
          end else begin
            level_d = lv_round[LEVEL_W-1:0];
          end
          count_d = count_q + LEN_W'(1);
          state_d = SQ_MSP_GO;
        end
      end
      SQ_MSP_GO: begin
        mul_start = 1'b1;
        state_d   = SQ_MSP_WAIT;
      end
      // sample times level, floor after the half offset, saturated
      SQ_MSP_WAIT: begin
        if (mul_done) begin
          if (smp_shift > SmpMax) begin
            res_d = SmpMax[SAMPLE_BITS-1:0];
          end else if (smp_shift < SmpMin) begin
            res_d = SmpMin[SAMPLE_BITS-1:0];
          end else begin
            res_d = smp_shift[SAMPLE_BITS-1:0];
          end
          state_d = SQ_OUT;
        end
      end
      SQ_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.sample_out = res_q;
          out_d.stage_now  = stage_q;
          out_d.level_now  = level_q;
          out_valid_d      = 1'b1;
          state_d          = SQ_IDLE;
        end
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  // control and envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SQ_IDLE;
      stage_q     <= ST_OFF;
      level_q     <= '0;
      factor_q    <= Q30_ONE;
      count_q     <= '0;
      end_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      level_q     <= level_d;
      factor_q    <= factor_d;
      count_q     <= count_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atk_len_q <= ATTACK_LEN_RST;
      dec_len_q <= DECAY_LEN_RST;
      rel_len_q <= RELEASE_LEN_RST;
      sus_q     <= SUSTAIN_RST;
      floor_q   <= FLOOR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ATTACK_LEN:  atk_len_q <= cfg_data_i[LEN_W-1:0];
        CFG_DECAY_LEN:   dec_len_q <= cfg_data_i[LEN_W-1:0];
        CFG_RELEASE_LEN: rel_len_q <= cfg_data_i[LEN_W-1:0];
        CFG_SUSTAIN:     sus_q     <= cfg_data_i;
        CFG_FLOOR:       floor_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    is_cmd_q   <= is_cmd_d;
    fa_start_q <= fa_start_d;
    fa_end_q   <= fa_end_d;
    lnend_q    <= lnend_d;
    lnstart_q  <= lnstart_d;
    sample_q   <= sample_d;
    res_q      <= res_d;
  end

  eae_log #(
    .DEPTH(LOG_TABLE_DEPTH)
  ) u_log (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(log_start),
    .x_i    (log_x),
    .done_o (log_done),
    .ln_o   (log_ln)
  );

  eae_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (NUM_W'(lnend_q) - NUM_W'(lnstart_q)),
    .len_i   (end_q),
    .done_o  (div_done),
    .factor_o(div_factor)
  );

  eae_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `EAE_ASSERT_NEXT(a_accept_leaves_idle, in_valid_i && in_ready_o, state_q != SQ_IDLE)
  `EAE_ASSERT(a_off_is_silent, (stage_q != ST_OFF) || (level_q == '0 && factor_q == Q30_ONE))
  `EAE_ASSERT(a_sustain_flat, (stage_q != ST_SUSTAIN) || (factor_q == Q30_ONE))

endmodule

// File: rtl/core/eae_log.sv
// Natural log of a Q1.24 level: bit-serial normalize, then table interpolation.
module eae_log import eae_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [LEVEL_W-1:0]     x_i,
  output logic                   done_o,
  output logic signed [LN_W-1:0] ln_o
);

  localparam int IW = $clog2(DEPTH);
  localparam int TW = $clog2(DEPTH + 1);
  localparam int PW = 30 + TW;

  // ln table, constant logic
  logic [30:0] tab_w [DEPTH+1];
  for (genvar k = 0; k <= DEPTH; k++) begin : g_tab
    localparam logic [30:0] Entry = 31'(ln_entry(k, DEPTH));
    assign tab_w[k] = Entry;
  end

  log_e                   state_q, state_d;
  logic                   done_q, done_d;
  logic [LEVEL_W-1:0]     sh_q, sh_d;
  logic signed [LN_W-1:0] acc_q, acc_d;
  logic [PW-1:0]          pos_q, pos_d;
  logic [30:0]            lo_q, lo_d, hi_q, hi_d;
  logic [29:0]            rem_q, rem_d;
  logic [30:0]            ip_q, ip_d;
  logic signed [LN_W-1:0] ln_q, ln_d;

  logic [29:0]   frac;
  logic [IW-1:0] idx;
  logic [TW-1:0] tidx;
  logic [30:0]   diff;
  logic [60:0]   iprod;

  assign frac  = {sh_q[LEVEL_W-2:0], 6'b0};
  assign idx   = pos_q[30 +: IW];
  assign tidx  = TW'(idx);
  assign diff  = hi_q - lo_q;
  assign iprod = 61'(diff) * 61'(rem_q);

  // Sequence: normalize one bit a cycle, scale, look up, interpolate, sum
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    sh_d    = sh_q;
    acc_d   = acc_q;
    pos_d   = pos_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    rem_d   = rem_q;
    ip_d    = ip_q;
    ln_d    = ln_q;
    case (state_q)
      LG_IDLE: begin
        if (start_i) begin
          sh_d    = (x_i == '0) ? LEVEL_W'(1) : x_i;
          acc_d   = '0;
          state_d = LG_NORM;
        end
      end
      LG_NORM: begin
        if (sh_q[LEVEL_W-1]) begin
          pos_d   = PW'(frac) * PW'(DEPTH);
          state_d = LG_POS;
        end else begin
          sh_d  = sh_q << 1;
          acc_d = acc_q - LN2_Q30;
        end
      end
      LG_POS: begin
        lo_d    = tab_w[tidx];
        hi_d    = tab_w[tidx + TW'(1)];
        rem_d   = pos_q[29:0];
        state_d = LG_LOOK;
      end
      LG_LOOK: begin
        ip_d    = iprod[60:30];
        state_d = LG_MUL;
      end
      LG_MUL: begin
        ln_d    = acc_q + $signed(LN_W'(lo_q)) + $signed(LN_W'(ip_q));
        done_d  = 1'b1;
        state_d = LG_IDLE;
      end
      default: state_d = LG_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LG_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    acc_q <= acc_d;
    pos_q <= pos_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    rem_q <= rem_d;
    ip_q  <= ip_d;
    ln_q  <= ln_d;
  end

  assign done_o = done_q;
  assign ln_o   = ln_q;

endmodule

// File: rtl/core/eae_div.sv
// Per-sample factor 1 + num/len: restoring divide one quotient bit a cycle.
module eae_div import eae_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [NUM_W-1:0]    num_i,
  input  logic [LEN_W-1:0]           len_i,
  output logic                       done_o,
  output logic signed [FACTOR_W-1:0] factor_o
);

  localparam logic signed [NUM_W+1:0] FMax = 39'sd2147483647;
  localparam logic signed [NUM_W+1:0] FMin = -39'sd2147483648;

  div_e                       state_q, state_d;
  logic                       done_q, done_d;
  logic                       neg_q, neg_d;
  logic [NUM_W-1:0]           dvd_q, dvd_d;
  logic [NUM_W-1:0]           quo_q, quo_d;
  logic [LEN_W-1:0]           rem_q, rem_d;
  logic [5:0]                 cnt_q, cnt_d;
  logic signed [FACTOR_W-1:0] fac_q, fac_d;

  logic [LEN_W:0]           trial;
  logic                     fits;
  logic signed [NUM_W:0]    q_s;
  logic signed [NUM_W+1:0]  f_s;

  assign trial = {rem_q, dvd_q[NUM_W-1]};
  assign fits  = trial >= (LEN_W+1)'(len_i);
  assign q_s   = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign f_s   = (NUM_W+2)'(q_s) + (NUM_W+2)'(Q30_ONE);

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    neg_d   = neg_q;
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    fac_d   = fac_q;
    case (state_q)
      DV_IDLE: begin
        if (start_i) begin
          neg_d   = num_i[NUM_W-1];
          dvd_d   = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
          quo_d   = '0;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = DV_RUN;
        end
      end
      // one dividend bit per cycle, truncating toward zero on magnitudes
      DV_RUN: begin
        rem_d = fits ? LEN_W'(trial - (LEN_W+1)'(len_i)) : LEN_W'(trial);
        quo_d = {quo_q[NUM_W-2:0], fits};
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(NUM_W - 1)) begin
          state_d = DV_FIX;
        end
      end
      // sign and saturate to Q2.30
      DV_FIX: begin
        if (f_s > FMax) begin
          fac_d = FMax[FACTOR_W-1:0];
        end else if (f_s < FMin) begin
          fac_d = FMin[FACTOR_W-1:0];
        end else begin
          fac_d = f_s[FACTOR_W-1:0];
        end
        done_d  = 1'b1;
        state_d = DV_IDLE;
      end
      default: state_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    fac_q <= fac_d;
  end

  assign done_o   = done_q;
  assign factor_o = fac_q;

endmodule

// File: rtl/core/eae_mul.sv
// Shift-add multiplier: unsigned level times signed operand, one level bit a cycle.
module eae_mul import eae_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [LEVEL_W-1:0]         a_i,
  input  logic signed [FACTOR_W-1:0] b_i,
  output logic                       done_o,
  output logic signed [PROD_W-1:0]   p_o
);

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [LEVEL_W-1:0]       a_q, a_d;
  logic signed [PROD_W-1:0] mc_q, mc_d;
  logic signed [PROD_W-1:0] acc_q, acc_d;
  logic [4:0]               cnt_q, cnt_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    a_d    = a_q;
    mc_d   = mc_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    if (busy_q) begin
      acc_d = a_q[0] ? acc_q + mc_q : acc_q;
      a_d   = a_q >> 1;
      mc_d  = mc_q <<< 1;
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(LEVEL_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      a_d    = a_i;
      mc_d   = PROD_W'(b_i);
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    mc_q  <= mc_d;
    acc_q <= acc_d;
    cnt_q <= cnt_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule
